// ----- sv/tmc_pkg.sv -----
// Shared types, codes and constants for the tilt motion classifier.
package tmc_pkg;

    // Field widths
    localparam int ANGLE_W  = 16;
    localparam int MAG_W    = 15;
    localparam int MOVED_W  = 16;
    localparam int INDEX_W  = 10;
    localparam int LIMIT_W  = 16;
    localparam int STAT_W   = 15;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DATA_W = 16;

    // Square-root datapath: operands are magnitudes or box spans
    localparam int OP_W    = ANGLE_W + 1;
    localparam int RAD_W   = 2 * OP_W;
    localparam int ROOT_W  = RAD_W / 2;
    localparam int REM_W   = ROOT_W + 2;
    localparam int STEPS   = RAD_W / 2;
    localparam int STEP_CNT_W = $clog2(STEPS + 1);

    // Register reset values
    localparam logic [LIMIT_W-1:0] SMALL_LIMIT_RST = 16'd1500;
    localparam logic [LIMIT_W-1:0] LARGE_LIMIT_RST = 16'd3000;
    localparam logic [STAT_W-1:0]  STAT_LIMIT_RST  = 15'd500;

    // Saturation points
    localparam logic [MAG_W-1:0]   MAG_MAX   = '1;
    localparam logic [MOVED_W-1:0] MOVED_MAX = '1;

    // Register indexes
    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_SMALL_LIMIT = 2'd0,
        CFG_LARGE_LIMIT = 2'd1,
        CFG_STAT_LIMIT  = 2'd2
    } cfg_index_t;

    // Request codes
    typedef enum logic {
        OP_SAMPLE = 1'b0,
        OP_FINISH = 1'b1
    } op_t;

    // Motion grades
    typedef enum logic [1:0] {
        CLASS_SMALL  = 2'd0,
        CLASS_MEDIUM = 2'd1,
        CLASS_LARGE  = 2'd2
    } motion_class_t;

    // Back-end sequencer states
    typedef enum logic [2:0] {
        BK_IDLE,
        BK_SQ_A,
        BK_SQ_B,
        BK_SQ_C,
        BK_ROOT,
        BK_RESULT
    } back_state_t;

    typedef struct packed {
        logic                      req_type;
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
    } in_item_t;

    typedef struct packed {
        logic                      is_summary;
        logic [MAG_W-1:0]          magnitude;
        logic [INDEX_W-1:0]        sample_index;
        logic                      dropped;
        logic [1:0]                motion_class;
        logic [MOVED_W-1:0]        box_diagonal;
        logic signed [ANGLE_W-1:0] displacement;
        logic                      stationary;
    } out_item_t;

    // Decoded command passed from front to back through the queue
    typedef struct packed {
        op_t                       op;
        logic signed [ANGLE_W-1:0] roll;
        logic signed [ANGLE_W-1:0] pitch;
        logic [OP_W-1:0]           roll_abs;
        logic [OP_W-1:0]           pitch_abs;
    } cmd_t;

    typedef struct packed {
        logic [LIMIT_W-1:0] small_limit;
        logic [LIMIT_W-1:0] large_limit;
        logic [STAT_W-1:0]  stat_limit;
    } cfg_t;

    // Queue status seen by the front and the back
    typedef struct packed {
        logic full;
        logic empty;
    } q_status_t;

endpackage

// ----- sv/tmc_if.sv -----
// Valid/ready channel interfaces for samples and results.
interface tmc_in_if;
    import tmc_pkg::*;
    logic     valid;
    logic     ready;
    in_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

interface tmc_out_if;
    import tmc_pkg::*;
    logic      valid;
    logic      ready;
    out_item_t item;

    modport source (output valid, output item, input ready);
    modport sink   (input valid, input item, output ready);
endinterface

// ----- sv/tmc_front.sv -----
// Front end: accepts requests, decodes them and pushes commands into the queue.
module tmc_front (
    tmc_in_if.sink            sample_ch,
    input  tmc_pkg::q_status_t q_status,
    output logic              push,
    output tmc_pkg::cmd_t     push_cmd
);
    import tmc_pkg::*;

    logic [OP_W-1:0] roll_ext;
    logic [OP_W-1:0] pitch_ext;

    // Accept whenever the queue has room
    assign sample_ch.ready = !q_status.full;
    assign push            = sample_ch.valid && !q_status.full;

    // Absolute values, one bit wider so that -32768 is exact
    assign roll_ext  = OP_W'(sample_ch.item.roll);
    assign pitch_ext = OP_W'(sample_ch.item.pitch);

    always_comb
    begin
        push_cmd.op    = sample_ch.item.req_type ? OP_FINISH : OP_SAMPLE;
        push_cmd.roll  = sample_ch.item.roll;
        push_cmd.pitch = sample_ch.item.pitch;
        push_cmd.roll_abs  = sample_ch.item.roll[ANGLE_W-1] ? (~roll_ext + 1'b1) : roll_ext;
        push_cmd.pitch_abs = sample_ch.item.pitch[ANGLE_W-1] ? (~pitch_ext + 1'b1) : pitch_ext;
    end

endmodule

// ----- sv/tmc_queue.sv -----
// Two-entry command queue between the front and back ends.
module tmc_queue (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               push,
    input  tmc_pkg::cmd_t      push_cmd,
    input  logic               pop,
    output tmc_pkg::cmd_t      pop_cmd,
    output tmc_pkg::q_status_t status
);
    import tmc_pkg::*;

    cmd_t       entry_reg [2];
    logic       wr_ptr_reg;
    logic       rd_ptr_reg;
    logic [1:0] count_reg;
    logic [1:0] count_next;

    assign status.full  = (count_reg == 2'd2);
    assign status.empty = (count_reg == 2'd0);
    assign pop_cmd      = entry_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
            count_next = count_reg + 2'd1;
        else if (pop && !push)
            count_next = count_reg - 2'd1;
    end

    // Pointers and fill count
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            if (push)
                wr_ptr_reg <= ~wr_ptr_reg;
            if (pop)
                rd_ptr_reg <= ~rd_ptr_reg;
            count_reg <= count_next;
        end
    end

    // Storage
    always_ff @(posedge clk)
    begin
        if (push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

// ----- sv/tmc_isqrt.sv -----
// Iterative floor square root, one result bit per cycle.
module tmc_isqrt (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       start,
    input  logic [tmc_pkg::RAD_W-1:0]  radicand,
    output logic                       done,
    output logic [tmc_pkg::ROOT_W-1:0] root
);
    import tmc_pkg::*;

    logic [RAD_W-1:0]      rad_reg;
    logic [REM_W-1:0]      rem_reg;
    logic [ROOT_W-1:0]     root_reg;
    logic [STEP_CNT_W-1:0] cnt_reg;
    logic                  busy_reg;
    logic                  done_reg;

    logic [REM_W-1:0] rem_shift;
    logic [REM_W-1:0] trial;
    logic             fits;

    assign root = root_reg;
    assign done = done_reg;

    // Bring down the next two radicand bits and try a one digit
    assign rem_shift = {rem_reg[REM_W-3:0], rad_reg[RAD_W-1:RAD_W-2]};
    assign trial     = {root_reg, 2'b01};
    assign fits      = (rem_shift >= trial);

    // Control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            if (start)
            begin
                busy_reg <= 1'b1;
                cnt_reg  <= STEP_CNT_W'(STEPS);
            end
            else if (busy_reg)
            begin
                cnt_reg <= cnt_reg - 1'b1;
                if (cnt_reg == STEP_CNT_W'(1))
                begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end
            end
        end
    end

    // Datapath
    always_ff @(posedge clk)
    begin
        if (start)
        begin
            rad_reg  <= radicand;
            rem_reg  <= '0;
            root_reg <= '0;
        end
        else if (busy_reg)
        begin
            rad_reg <= {rad_reg[RAD_W-3:0], 2'b00};
            if (fits)
            begin
                rem_reg  <= rem_shift - trial;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b1};
            end
            else
            begin
                rem_reg  <= rem_shift;
                root_reg <= {root_reg[ROOT_W-2:0], 1'b0};
            end
        end
    end

endmodule

// ----- sv/tmc_back.sv -----
// Back end: squares, square root, record state and the result register.
module tmc_back #(
    parameter int RECORD_DEPTH = 1024
) (
    input  logic               clk,
    input  logic               rst_n,
    input  tmc_pkg::cfg_t      cfg,
    input  tmc_pkg::q_status_t q_status,
    input  tmc_pkg::cmd_t      pop_cmd,
    output logic               pop,
    tmc_out_if.source          result_ch
);
    import tmc_pkg::*;

    localparam int CNT_W = $clog2(RECORD_DEPTH + 1);

    back_state_t state_reg;
    back_state_t state_next;

    cmd_t              cmd_reg;
    logic [RAD_W-1:0]  prod_reg;
    logic [RAD_W-1:0]  acc_reg;

    // Record state
    logic signed [ANGLE_W-1:0] roll_low_reg;
    logic signed [ANGLE_W-1:0] roll_high_reg;
    logic signed [ANGLE_W-1:0] pitch_low_reg;
    logic signed [ANGLE_W-1:0] pitch_high_reg;
    logic [MAG_W-1:0]          first_mag_reg;
    logic [MAG_W-1:0]          last_mag_reg;
    logic [CNT_W-1:0]          count_reg;

    logic      out_valid_reg;
    out_item_t out_item_reg;
    out_item_t out_item_next;

    logic                     sq_start;
    logic                     sq_done;
    logic [ROOT_W-1:0]        sq_root;
    logic signed [OP_W-1:0]   roll_span;
    logic signed [OP_W-1:0]   pitch_span;
    logic [OP_W-1:0]          op_a;
    logic [OP_W-1:0]          op_b;
    logic [OP_W-1:0]          mul_op;
    logic [RAD_W-1:0]         product;

    logic [MAG_W-1:0]          mag;
    logic [MOVED_W-1:0]        moved;
    logic                      full;
    logic [CNT_W+INDEX_W-1:0]  count_ext;
    logic signed [ANGLE_W-1:0] disp;
    logic [ANGLE_W-1:0]        adisp;
    motion_class_t             grade;

    // Sequencer
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= BK_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        pop        = 1'b0;
        sq_start   = 1'b0;
        case (state_reg)
            BK_IDLE:
            begin
                if (!q_status.empty && !out_valid_reg)
                begin
                    pop        = 1'b1;
                    state_next = BK_SQ_A;
                end
            end
            BK_SQ_A:   state_next = BK_SQ_B;
            BK_SQ_B:   state_next = BK_SQ_C;
            BK_SQ_C:
            begin
                sq_start   = 1'b1;
                state_next = BK_ROOT;
            end
            BK_ROOT:
            begin
                if (sq_done)
                    state_next = BK_RESULT;
            end
            BK_RESULT: state_next = BK_IDLE;
            default:   state_next = BK_IDLE;
        endcase
    end

    // Squaring operands: sample magnitudes or box spans (spans are never negative)
    assign roll_span  = OP_W'(roll_high_reg) - OP_W'(roll_low_reg);
    assign pitch_span = OP_W'(pitch_high_reg) - OP_W'(pitch_low_reg);
    assign op_a   = (cmd_reg.op == OP_FINISH) ? OP_W'(roll_span) : cmd_reg.roll_abs;
    assign op_b   = (cmd_reg.op == OP_FINISH) ? OP_W'(pitch_span) : cmd_reg.pitch_abs;
    assign mul_op = (state_reg == BK_SQ_A) ? op_a : op_b;
    assign product = RAD_W'(mul_op) * RAD_W'(mul_op);

    always_ff @(posedge clk)
    begin
        if (pop)
            cmd_reg <= pop_cmd;
        if (state_reg == BK_SQ_A || state_reg == BK_SQ_B)
            prod_reg <= product;
        if (state_reg == BK_SQ_B)
            acc_reg <= prod_reg;
    end

    tmc_isqrt u_isqrt (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (sq_start),
        .radicand (acc_reg + prod_reg),
        .done     (sq_done),
        .root     (sq_root)
    );

    // Result arithmetic
    assign mag   = (sq_root > ROOT_W'(MAG_MAX)) ? MAG_MAX : sq_root[MAG_W-1:0];
    assign moved = (sq_root > ROOT_W'(MOVED_MAX)) ? MOVED_MAX : sq_root[MOVED_W-1:0];
    assign full  = (count_reg >= CNT_W'(RECORD_DEPTH));
    assign count_ext = {{INDEX_W{1'b0}}, count_reg};
    assign disp  = $signed({1'b0, last_mag_reg}) - $signed({1'b0, first_mag_reg});
    assign adisp = disp[ANGLE_W-1] ? ANGLE_W'(-disp) : ANGLE_W'(disp);

    // Small test first, then large
    always_comb
    begin
        if (moved < cfg.small_limit)
            grade = CLASS_SMALL;
        else if (moved < cfg.large_limit)
            grade = CLASS_MEDIUM;
        else
            grade = CLASS_LARGE;
    end

    // Record state update
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            roll_low_reg   <= '0;
            roll_high_reg  <= '0;
            pitch_low_reg  <= '0;
            pitch_high_reg <= '0;
            first_mag_reg  <= '0;
            last_mag_reg   <= '0;
            count_reg      <= '0;
        end
        else if (state_reg == BK_RESULT)
        begin
            if (cmd_reg.op == OP_FINISH)
            begin
                roll_low_reg   <= '0;
                roll_high_reg  <= '0;
                pitch_low_reg  <= '0;
                pitch_high_reg <= '0;
                first_mag_reg  <= '0;
                last_mag_reg   <= '0;
                count_reg      <= '0;
            end
            else if (!full)
            begin
                if (count_reg == '0)
                    first_mag_reg <= mag;
                last_mag_reg <= mag;
                if (cmd_reg.roll < roll_low_reg)
                    roll_low_reg <= cmd_reg.roll;
                if (cmd_reg.roll > roll_high_reg)
                    roll_high_reg <= cmd_reg.roll;
                if (cmd_reg.pitch < pitch_low_reg)
                    pitch_low_reg <= cmd_reg.pitch;
                if (cmd_reg.pitch > pitch_high_reg)
                    pitch_high_reg <= cmd_reg.pitch;
                count_reg <= count_reg + 1'b1;
            end
        end
    end

    // Result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else if (state_reg == BK_RESULT)
            out_valid_reg <= 1'b1;
        else if (result_ch.ready)
            out_valid_reg <= 1'b0;
    end

    // Result fields; the ones that do not apply stay zero
    always_comb
    begin
        out_item_next = '0;
        if (cmd_reg.op == OP_FINISH)
        begin
            out_item_next.is_summary   = 1'b1;
            out_item_next.motion_class = grade;
            out_item_next.box_diagonal = moved;
            out_item_next.displacement = disp;
            out_item_next.stationary   = (adisp < ANGLE_W'(cfg.stat_limit));
        end
        else
        begin
            out_item_next.magnitude    = mag;
            out_item_next.dropped      = full;
            out_item_next.sample_index = full ? '0 : count_ext[INDEX_W-1:0];
        end
    end

    always_ff @(posedge clk)
    begin
        if (state_reg == BK_RESULT)
            out_item_reg <= out_item_next;
    end

    assign result_ch.valid = out_valid_reg;
    assign result_ch.item  = out_item_reg;

endmodule

// ----- sv/tilt_motion_classifier_top.sv -----
// Top level of the tilt motion classifier: channels, registers, front, queue and back.
//
// Each request (tilt sample or finish) goes through the back end in order: it is
// picked from the queue, the sum of squares is formed on a single 17x17 multiplier,
// the bit-serial square root runs until its done flag, the result and state are
// updated, and the next pick waits until the result register is free.
// The square-root unit is shared by the sample magnitude and the summary diagonal,
// so the back end handles one request at a time; a two-entry queue lets the input
// side keep accepting while a result waits to be taken. Writes to the limit
// registers are taken at any time and act on the next summary.
module tilt_motion_classifier_top #(
    parameter int RECORD_DEPTH = 1024
) (
    input  logic                               clk,
    input  logic                               rst_n,
    tmc_in_if.sink                             sample_ch,
    tmc_out_if.source                          result_ch,
    input  logic                               cfg_wr_en,
    input  logic [tmc_pkg::CFG_IDX_W-1:0]      cfg_index,
    input  logic [tmc_pkg::CFG_DATA_W-1:0]     cfg_data
);
    import tmc_pkg::*;

    cfg_t      cfg_reg;
    q_status_t q_status;
    logic      push;
    logic      pop;
    cmd_t      push_cmd;
    cmd_t      pop_cmd;

    // Limit registers; writes to an unused index are dropped
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.small_limit <= SMALL_LIMIT_RST;
            cfg_reg.large_limit <= LARGE_LIMIT_RST;
            cfg_reg.stat_limit  <= STAT_LIMIT_RST;
        end
        else if (cfg_wr_en)
        begin
            case (cfg_index)
                CFG_SMALL_LIMIT: cfg_reg.small_limit <= cfg_data[LIMIT_W-1:0];
                CFG_LARGE_LIMIT: cfg_reg.large_limit <= cfg_data[LIMIT_W-1:0];
                CFG_STAT_LIMIT:  cfg_reg.stat_limit  <= cfg_data[STAT_W-1:0];
                default: ;
            endcase
        end
    end

    tmc_front u_front (
        .sample_ch (sample_ch),
        .q_status  (q_status),
        .push      (push),
        .push_cmd  (push_cmd)
    );

    tmc_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_cmd (push_cmd),
        .pop      (pop),
        .pop_cmd  (pop_cmd),
        .status   (q_status)
    );

    tmc_back #(
        .RECORD_DEPTH (RECORD_DEPTH)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg       (cfg_reg),
        .q_status  (q_status),
        .pop_cmd   (pop_cmd),
        .pop       (pop),
        .result_ch (result_ch)
    );

endmodule

// ----- tb/tilt_motion_classifier_top_tb.sv -----
// Self-checking testbench: drives samples and finishes, predicts every result and compares.
`timescale 1ns / 100ps

module tilt_motion_classifier_top_tb;
    import tmc_pkg::*;

    localparam int RECORD_DEPTH = 1024;
    localparam int PHASE_ITEMS  = 190;
    // Pause after the last result has come back
    localparam int DRAIN_PAUSE  = 30;
    localparam logic [CFG_IDX_W-1:0] CFG_SPARE_INDEX = 2'd3;

    logic clk;
    logic rst_n;
    logic                  cfg_wr_en;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;

    tmc_in_if  sample_ch ();
    tmc_out_if result_ch ();

    // Predictor copy of the limit registers
    logic [LIMIT_W-1:0] small_limit;
    logic [LIMIT_W-1:0] large_limit;
    logic [STAT_W-1:0]  stat_limit;

    // Predictor copy of the open record
    logic signed [ANGLE_W-1:0] roll_min;
    logic signed [ANGLE_W-1:0] roll_max;
    logic signed [ANGLE_W-1:0] pitch_min;
    logic signed [ANGLE_W-1:0] pitch_max;
    logic [MAG_W-1:0]          start_mag;
    logic [MAG_W-1:0]          end_mag;
    int unsigned               samples_held;

    out_item_t pending_results[$];
    int        mismatches = 0;
    int        results_seen = 0;
    int        send_idle_pct;
    int        stall_pct;

    tilt_motion_classifier_top #(
        .RECORD_DEPTH(RECORD_DEPTH)
    ) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .sample_ch (sample_ch),
        .result_ch (result_ch),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Run limit
    initial
    begin
        #(5_000_000);
        $display("tilt_motion_classifier_top_tb NOT OK");
        $finish;
    end

    // Floor square root, built one bit at a time from the top
    function automatic longint unsigned floor_root(longint unsigned n);
        longint unsigned root;
        longint unsigned trial;
        root = 0;
        for (int b = 20; b >= 0; b--)
        begin
            trial = root | (64'd1 << b);
            if (trial * trial <= n)
                root = trial;
        end
        return root;
    endfunction

    function automatic void clear_record();
        roll_min     = '0;
        roll_max     = '0;
        pitch_min    = '0;
        pitch_max    = '0;
        start_mag    = '0;
        end_mag      = '0;
        samples_held = 0;
    endfunction

    // Expected result of one request; updates the record state
    function automatic out_item_t predict_result(in_item_t req);
        out_item_t       res;
        longint          r;
        longint          p;
        longint          span_r;
        longint          span_p;
        longint unsigned root;
        int              disp;
        int              disp_abs;
        res = '0;
        if (req.req_type == OP_SAMPLE)
        begin
            r = req.roll;
            p = req.pitch;
            root = floor_root(r * r + p * p);
            res.magnitude = (root > MAG_MAX) ? MAG_MAX : root[MAG_W-1:0];
            if (samples_held >= RECORD_DEPTH)
            begin
                // record full: sample is dropped, state untouched
                res.dropped = 1'b1;
                return res;
            end
            if (samples_held == 0)
                start_mag = res.magnitude;
            end_mag = res.magnitude;
            if (req.roll < roll_min)   roll_min  = req.roll;
            if (req.roll > roll_max)   roll_max  = req.roll;
            if (req.pitch < pitch_min) pitch_min = req.pitch;
            if (req.pitch > pitch_max) pitch_max = req.pitch;
            res.sample_index = INDEX_W'(samples_held % 1024);
            samples_held++;
        end
        else
        begin
            span_r = longint'(roll_max) - longint'(roll_min);
            span_p = longint'(pitch_max) - longint'(pitch_min);
            root = floor_root(span_r * span_r + span_p * span_p);
            res.is_summary   = 1'b1;
            res.box_diagonal = (root > MOVED_MAX) ? MOVED_MAX : root[MOVED_W-1:0];
            // small test first, so crossed limits never give medium
            if (res.box_diagonal < small_limit)
                res.motion_class = CLASS_SMALL;
            else if (res.box_diagonal < large_limit)
                res.motion_class = CLASS_MEDIUM;
            else
                res.motion_class = CLASS_LARGE;
            disp = int'(end_mag) - int'(start_mag);
            disp_abs = (disp < 0) ? -disp : disp;
            res.displacement = disp[ANGLE_W-1:0];
            res.stationary   = (disp_abs < int'(stat_limit));
            clear_record();
        end
        return res;
    endfunction

    task automatic flag_mismatch(string field, logic signed [31:0] got,
                                 logic signed [31:0] want);
        $display("%t result %0d: %s got %0d expected %0d",
                 $realtime, results_seen, field, got, want);
        mismatches++;
    endtask

    // Receiver: random stall and per-field check of each result transaction
    always @(posedge clk)
    begin
        out_item_t got;
        out_item_t want;
        result_ch.ready <= ($urandom_range(99) >= stall_pct);
        if (rst_n && result_ch.valid && result_ch.ready)
        begin
            got = result_ch.item;
            if (pending_results.size() == 0)
                flag_mismatch("result with nothing pending, is_summary", got.is_summary, 0);
            else
            begin
                want = pending_results.pop_front();
                if (got.is_summary !== want.is_summary)
                    flag_mismatch("is_summary", got.is_summary, want.is_summary);
                if (got.magnitude !== want.magnitude)
                    flag_mismatch("magnitude", got.magnitude, want.magnitude);
                if (got.sample_index !== want.sample_index)
                    flag_mismatch("sample_index", got.sample_index, want.sample_index);
                if (got.dropped !== want.dropped)
                    flag_mismatch("dropped", got.dropped, want.dropped);
                if (got.motion_class !== want.motion_class)
                    flag_mismatch("motion_class", got.motion_class, want.motion_class);
                if (got.box_diagonal !== want.box_diagonal)
                    flag_mismatch("box_diagonal", got.box_diagonal, want.box_diagonal);
                if (got.displacement !== want.displacement)
                    flag_mismatch("displacement", got.displacement, want.displacement);
                if (got.stationary !== want.stationary)
                    flag_mismatch("stationary", got.stationary, want.stationary);
            end
            results_seen++;
        end
    end

    // Sends one request; returns at the edge where it was accepted
    task automatic send_item(op_t op, logic signed [ANGLE_W-1:0] roll_v,
                             logic signed [ANGLE_W-1:0] pitch_v);
        in_item_t req;
        req.req_type = op;
        req.roll     = roll_v;
        req.pitch    = pitch_v;
        while ($urandom_range(99) < send_idle_pct)
        begin
            sample_ch.valid <= 1'b0;
            @(posedge clk);
        end
        sample_ch.valid <= 1'b1;
        sample_ch.item  <= req;
        @(posedge clk);
        while (!sample_ch.ready)
            @(posedge clk);
        pending_results.push_back(predict_result(req));
    endtask

    // Stop sending and wait until every pending result has come back
    task automatic wait_drained();
        sample_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_PAUSE) @(posedge clk);
    endtask

    // Leaves the write enable high; the caller lowers it after the last write
    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        @(posedge clk);
        case (idx)
            CFG_SMALL_LIMIT: small_limit = val;
            CFG_LARGE_LIMIT: large_limit = val;
            CFG_STAT_LIMIT:  stat_limit  = val[STAT_W-1:0];
            default: ;
        endcase
    endtask

    task automatic set_limits(logic [CFG_DATA_W-1:0] small_v, logic [CFG_DATA_W-1:0] large_v,
                              logic [CFG_DATA_W-1:0] stat_v);
        wait_drained();
        write_reg(CFG_SMALL_LIMIT, small_v);
        write_reg(CFG_LARGE_LIMIT, large_v);
        write_reg(CFG_STAT_LIMIT, stat_v);
        cfg_wr_en <= 1'b0;
    endtask

    // Angle draw: narrow, in range or any 16-bit value, with the range ends now and then
    function automatic logic signed [ANGLE_W-1:0] rand_angle(int spread);
        int a;
        if ($urandom_range(15) == 0)
            a = $urandom_range(1) ? 18000 : -18000;
        else if (spread == 0)
            a = int'($urandom_range(3000)) - 1500;
        else if (spread == 1)
            a = int'($urandom_range(36000)) - 18000;
        else
            a = $urandom;
        return a[ANGLE_W-1:0];
    endfunction

    function automatic logic [CFG_DATA_W-1:0] rand_limit(int unsigned top);
        case ($urandom_range(7))
            0:       return '0;
            1:       return '1;
            2:       return CFG_DATA_W'($urandom);
            default: return CFG_DATA_W'($urandom_range(top));
        endcase
    endfunction

    // Finish with nothing recorded, reset limits
    task automatic test_empty_record();
        send_item(OP_FINISH, 16'sd0, 16'sd0);
    endtask

    // Field extremes, a zero roll sample and saturation of both roots
    task automatic test_sample_extremes();
        send_item(OP_SAMPLE, 16'sd0, 16'sd0);
        send_item(OP_SAMPLE, 16'sd18000, 16'sd0);
        send_item(OP_SAMPLE, 16'sd0, 16'sd18000);
        send_item(OP_SAMPLE, -16'sd18000, -16'sd18000);
        send_item(OP_SAMPLE, 16'sd18000, 16'sd18000);
        send_item(OP_SAMPLE, -16'sd32768, -16'sd32768);
        send_item(OP_SAMPLE, 16'sd32767, 16'sd32767);
        send_item(OP_FINISH, 16'sd32767, -16'sd32768);
    endtask

    // Class boundaries with reset limits, displacement of both signs
    task automatic test_motion_classes();
        send_item(OP_SAMPLE, 16'sd1499, 16'sd0);
        send_item(OP_FINISH, 16'sd0, 16'sd0);
        send_item(OP_SAMPLE, 16'sd1500, 16'sd0);
        send_item(OP_FINISH, 16'sd0, 16'sd0);
        send_item(OP_SAMPLE, 16'sd3000, 16'sd0);
        send_item(OP_FINISH, 16'sd0, 16'sd0);
        send_item(OP_SAMPLE, 16'sd100, 16'sd0);
        send_item(OP_SAMPLE, 16'sd0, 16'sd2000);
        send_item(OP_FINISH, 16'sd0, 16'sd0);
        send_item(OP_SAMPLE, 16'sd0, 16'sd2000);
        send_item(OP_SAMPLE, 16'sd0, -16'sd100);
        send_item(OP_FINISH, 16'sd0, 16'sd0);
    endtask

    // Crossed limits, the unused register index, and limit extremes
    task automatic test_register_writes();
        set_limits(16'd3000, 16'd1000, 16'd0);
        send_item(OP_SAMPLE, 16'sd2000, 16'sd0);
        send_item(OP_FINISH, 16'sd0, 16'sd0);
        wait_drained();
        write_reg(CFG_SPARE_INDEX, 16'd0);
        cfg_wr_en <= 1'b0;
        send_item(OP_SAMPLE, 16'sd500, 16'sd0);
        send_item(OP_FINISH, 16'sd0, 16'sd0);
        set_limits(16'd0, 16'd0, 16'h7FFF);
        send_item(OP_FINISH, 16'sd0, 16'sd0);
        set_limits(16'hFFFF, 16'hFFFF, 16'hFFFF);
        send_item(OP_SAMPLE, -16'sd32768, -16'sd32768);
        send_item(OP_FINISH, 16'sd0, 16'sd0);
        set_limits(SMALL_LIMIT_RST, LARGE_LIMIT_RST, {1'b0, STAT_LIMIT_RST});
    endtask

    // Random records under one idling setting
    task automatic run_random_phase(int idle_v, int stall_v);
        int sent;
        int len;
        int spread;
        set_limits(rand_limit(50912), rand_limit(50912), rand_limit(25456));
        send_idle_pct = idle_v;
        stall_pct     = stall_v;
        sent = 0;
        while (sent < PHASE_ITEMS)
        begin
            // hold off now and then until the block has emptied
            if ($urandom_range(9) == 0)
                wait_drained();
            len = ($urandom_range(3) == 0) ? $urandom_range(3) : $urandom_range(25, 1);
            spread = $urandom_range(9);
            spread = (spread < 3) ? 0 : (spread < 9) ? 1 : 2;
            for (int i = 0; i < len; i++)
                send_item(OP_SAMPLE, rand_angle(spread), rand_angle(spread));
            send_item(OP_FINISH, rand_angle(2), rand_angle(2));
            sent += len + 1;
        end
    endtask

    task automatic test_random_traffic();
        run_random_phase(0, 0);
        run_random_phase(86, 0);
        run_random_phase(0, 86);
        run_random_phase(33, 33);
    endtask

    // Test sequence
    initial
    begin
        rst_n           <= 1'b0;
        cfg_wr_en       <= 1'b0;
        cfg_index       <= CFG_SMALL_LIMIT;
        cfg_data        <= '0;
        sample_ch.valid <= 1'b0;
        sample_ch.item  <= '0;
        send_idle_pct   = 0;
        stall_pct       = 0;
        small_limit     = SMALL_LIMIT_RST;
        large_limit     = LARGE_LIMIT_RST;
        stat_limit      = STAT_LIMIT_RST;
        clear_record();
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_empty_record();
        test_sample_extremes();
        test_motion_classes();
        test_register_writes();
        test_random_traffic();
        wait_drained();

        if (mismatches == 0)
            $display("tilt_motion_classifier_top_tb OK");
        else
            $display("tilt_motion_classifier_top_tb NOT OK");
        $finish;
    end

endmodule
